/* rtl/core/h2r_pkg.sv */
package h2r_pkg;

    // Hue circle and fixed-point scale.
    localparam int unsigned HUE_TURN    = 5760;
    localparam int unsigned HUE_SECTOR  = 960;
    localparam int unsigned FRAC_ONE    = 255;
    localparam int unsigned FULL_X      = FRAC_ONE * HUE_SECTOR;
    localparam int unsigned DENOM       = FULL_X * FRAC_ONE;

    // floor(31 * 2^32 / DENOM): the quotient estimate is low by at most one.
    localparam int unsigned RECIP       = 2132;
    localparam int unsigned RECIP_SHIFT = 32;

    localparam int HUE_W  = 13;
    localparam int POS_W  = 10;
    localparam int X_W    = 18;
    localparam int NUM_W  = 26;
    localparam int Y_W    = 31;
    localparam int PROD_W = 37;
    localparam int CH_W   = 5;

    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } sector_t;

    typedef logic [X_W-1:0]   frac_t;
    typedef logic [NUM_W-1:0] num_t;
    typedef logic [CH_W-1:0]  chan_t;

    typedef struct packed {
        logic [15:0] hue;
        logic [7:0]  saturation;
        logic [7:0]  brightness;
    } hsv_word_t;

    typedef struct packed {
        logic [15:0] packed_color;
        logic [4:0]  red5;
        logic [4:0]  green5;
        logic [4:0]  blue5;
    } rgb_word_t;

    // Load enables of a two-stage section.
    typedef struct packed {
        logic first;
        logic second;
    } pair_en_t;

    // Scaled value at which the channel reaches qe + 1.
    function automatic logic [Y_W-1:0] step_bound(input chan_t qe);
        logic [Y_W-1:0] idx;
        idx = {{(Y_W-CH_W){1'b0}}, qe} + Y_W'(1);
        return Y_W'(idx * Y_W'(DENOM));
    endfunction

endpackage

/* rtl/core/h2r_sector.sv */
module h2r_sector (
    input  logic                          aclk,
    input  logic                          en,
    input  h2r_pkg::hsv_word_t            in_word,
    output h2r_pkg::sector_t              sector,
    output logic [h2r_pkg::POS_W-1:0]     pos,
    output logic [7:0]                    sat,
    output logic [7:0]                    bri
);

    logic [h2r_pkg::HUE_W-1:0] hue_w;
    logic [h2r_pkg::HUE_W-1:0] base;
    h2r_pkg::sector_t          sector_next;
    h2r_pkg::sector_t          sector_reg;
    logic [h2r_pkg::POS_W-1:0] pos_next;
    logic [h2r_pkg::POS_W-1:0] pos_reg;
    logic [7:0]                sat_reg;
    logic [7:0]                bri_reg;

    // A hue of a full turn or more wraps to zero.
    always_comb begin
        if (in_word.hue >= 16'(h2r_pkg::HUE_TURN)) begin
            hue_w = '0;
        end else begin
            hue_w = in_word.hue[h2r_pkg::HUE_W-1:0];
        end
    end

    always_comb begin
        priority if (hue_w >= h2r_pkg::HUE_W'(5 * h2r_pkg::HUE_SECTOR)) begin
            sector_next = h2r_pkg::SEC_MAG_RED;
            base        = h2r_pkg::HUE_W'(5 * h2r_pkg::HUE_SECTOR);
        end else if (hue_w >= h2r_pkg::HUE_W'(4 * h2r_pkg::HUE_SECTOR)) begin
            sector_next = h2r_pkg::SEC_BLU_MAG;
            base        = h2r_pkg::HUE_W'(4 * h2r_pkg::HUE_SECTOR);
        end else if (hue_w >= h2r_pkg::HUE_W'(3 * h2r_pkg::HUE_SECTOR)) begin
            sector_next = h2r_pkg::SEC_CYN_BLU;
            base        = h2r_pkg::HUE_W'(3 * h2r_pkg::HUE_SECTOR);
        end else if (hue_w >= h2r_pkg::HUE_W'(2 * h2r_pkg::HUE_SECTOR)) begin
            sector_next = h2r_pkg::SEC_GRN_CYN;
            base        = h2r_pkg::HUE_W'(2 * h2r_pkg::HUE_SECTOR);
        end else if (hue_w >= h2r_pkg::HUE_W'(h2r_pkg::HUE_SECTOR)) begin
            sector_next = h2r_pkg::SEC_YEL_GRN;
            base        = h2r_pkg::HUE_W'(h2r_pkg::HUE_SECTOR);
        end else begin
            sector_next = h2r_pkg::SEC_RED_YEL;
            base        = '0;
        end
        pos_next = h2r_pkg::POS_W'(hue_w - base);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sector_reg <= sector_next;
            pos_reg    <= pos_next;
            sat_reg    <= in_word.saturation;
            bri_reg    <= in_word.brightness;
        end
    end

    assign sector = sector_reg;
    assign pos    = pos_reg;
    assign sat    = sat_reg;
    assign bri    = bri_reg;

endmodule

/* rtl/core/h2r_chan_num.sv */
module h2r_chan_num (
    input  logic                          aclk,
    input  h2r_pkg::pair_en_t             en,
    input  h2r_pkg::sector_t              sector,
    input  logic [h2r_pkg::POS_W-1:0]     pos,
    input  logic [7:0]                    sat,
    input  logic [7:0]                    bri,
    output h2r_pkg::num_t                 red_num,
    output h2r_pkg::num_t                 green_num,
    output h2r_pkg::num_t                 blue_num
);

    localparam int PadS = h2r_pkg::X_W - 8;
    localparam int PadP = h2r_pkg::X_W - h2r_pkg::POS_W;
    localparam int PadB = h2r_pkg::NUM_W - 8;
    localparam int PadX = h2r_pkg::NUM_W - h2r_pkg::X_W;

    h2r_pkg::frac_t            x_full;
    h2r_pkg::frac_t            x_p;
    h2r_pkg::frac_t            x_q;
    h2r_pkg::frac_t            x_t;
    logic [h2r_pkg::POS_W-1:0] rest;
    h2r_pkg::frac_t            xr_next;
    h2r_pkg::frac_t            xg_next;
    h2r_pkg::frac_t            xb_next;
    h2r_pkg::frac_t            xr_reg;
    h2r_pkg::frac_t            xg_reg;
    h2r_pkg::frac_t            xb_reg;
    logic [7:0]                bri_reg;
    h2r_pkg::num_t             nr_reg;
    h2r_pkg::num_t             ng_reg;
    h2r_pkg::num_t             nb_reg;

    // Numerators over 255 * 960, before the brightness factor. With zero
    // saturation all of them equal the full scale, which gives grey.
    always_comb begin
        x_full = h2r_pkg::X_W'(h2r_pkg::FULL_X);
        rest   = h2r_pkg::POS_W'(h2r_pkg::HUE_SECTOR) - pos;
        x_p    = {{PadS{1'b0}}, 8'(h2r_pkg::FRAC_ONE) - sat}
                 * h2r_pkg::X_W'(h2r_pkg::HUE_SECTOR);
        x_q    = x_full - ({{PadS{1'b0}}, sat} * {{PadP{1'b0}}, pos});
        x_t    = x_full - ({{PadS{1'b0}}, sat} * {{PadP{1'b0}}, rest});
    end

    always_comb begin
        unique case (sector)
            h2r_pkg::SEC_RED_YEL: begin
                xr_next = x_full; xg_next = x_t;    xb_next = x_p;
            end
            h2r_pkg::SEC_YEL_GRN: begin
                xr_next = x_q;    xg_next = x_full; xb_next = x_p;
            end
            h2r_pkg::SEC_GRN_CYN: begin
                xr_next = x_p;    xg_next = x_full; xb_next = x_t;
            end
            h2r_pkg::SEC_CYN_BLU: begin
                xr_next = x_p;    xg_next = x_q;    xb_next = x_full;
            end
            h2r_pkg::SEC_BLU_MAG: begin
                xr_next = x_t;    xg_next = x_p;    xb_next = x_full;
            end
            h2r_pkg::SEC_MAG_RED: begin
                xr_next = x_full; xg_next = x_p;    xb_next = x_q;
            end
            default: begin
                xr_next = x_full; xg_next = x_p;    xb_next = x_q;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en.first) begin
            xr_reg  <= xr_next;
            xg_reg  <= xg_next;
            xb_reg  <= xb_next;
            bri_reg <= bri;
        end
        if (en.second) begin
            nr_reg <= {{PadB{1'b0}}, bri_reg} * {{PadX{1'b0}}, xr_reg};
            ng_reg <= {{PadB{1'b0}}, bri_reg} * {{PadX{1'b0}}, xg_reg};
            nb_reg <= {{PadB{1'b0}}, bri_reg} * {{PadX{1'b0}}, xb_reg};
        end
    end

    assign red_num   = nr_reg;
    assign green_num = ng_reg;
    assign blue_num  = nb_reg;

endmodule

/* rtl/core/h2r_div31.sv */
module h2r_div31 (
    input  logic              aclk,
    input  h2r_pkg::pair_en_t en,
    input  h2r_pkg::num_t     num,
    output h2r_pkg::chan_t    chan
);

    localparam int PadN = h2r_pkg::PROD_W - h2r_pkg::NUM_W;
    localparam int PadY = h2r_pkg::Y_W - h2r_pkg::NUM_W;

    logic [h2r_pkg::PROD_W-1:0] prod_next;
    logic [h2r_pkg::PROD_W-1:0] prod_reg;
    logic [h2r_pkg::Y_W-1:0]    y_next;
    logic [h2r_pkg::Y_W-1:0]    y_reg;
    h2r_pkg::chan_t             qe;
    h2r_pkg::chan_t             chan_next;
    h2r_pkg::chan_t             chan_reg;

    // The reciprocal product gives the quotient or one less; the scaled
    // numerator 31 * num is kept beside it to settle which.
    always_comb begin
        prod_next = {{PadN{1'b0}}, num} * h2r_pkg::PROD_W'(h2r_pkg::RECIP);
        y_next    = {num, {PadY{1'b0}}} - {{PadY{1'b0}}, num};
        qe        = prod_reg[h2r_pkg::RECIP_SHIFT +: h2r_pkg::CH_W];
        if (y_reg >= h2r_pkg::step_bound(qe)) begin
            chan_next = qe + h2r_pkg::CH_W'(1);
        end else begin
            chan_next = qe;
        end
    end

    always_ff @(posedge aclk) begin
        if (en.first) begin
            prod_reg <= prod_next;
            y_reg    <= y_next;
        end
        if (en.second) begin
            chan_reg <= chan_next;
        end
    end

    assign chan = chan_reg;

endmodule

/* rtl/core/hsv_to_rgba5551.sv */
// HSV to RGBA5551 color converter.
//
// The input channel (s_valid, s_ready, s_word) carries one HSV word: hue in
// 1/16 degree, where a full turn or more wraps to zero, and saturation and
// brightness as 8-bit fractions with 255 meaning one. The result channel
// (m_valid, m_ready, m_word) returns one word per input word, in order: the
// three 5-bit channels, truncated exactly, and the packed RGBA5551 color with
// alpha set.
//
// The pipeline has five register stages: sector decode, numerator select,
// brightness multiply, reciprocal multiply, and quotient correction into the
// output register. An accepted word passes through these registers in order;
// m_valid rises once it is in the output register, and it leaves when the
// receiver takes it. One word can be taken in every cycle while the receiver
// keeps up or a stage is empty. Each stage moves when it is empty or when the
// stage after it moves, so bubbles are squeezed out while the receiver stalls;
// s_ready falls only once all five stages hold a word.
//
// Reset clears all stage valid flags; no word is in flight afterward.
module hsv_to_rgba5551 (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  h2r_pkg::hsv_word_t s_word,
    output logic               m_valid,
    input  logic               m_ready,
    output h2r_pkg::rgb_word_t m_word
);

    logic [4:0]                vld_reg;
    logic [4:0]                vld_next;
    logic [4:0]                load;
    h2r_pkg::pair_en_t         num_en;
    h2r_pkg::pair_en_t         div_en;
    h2r_pkg::sector_t          sector;
    logic [h2r_pkg::POS_W-1:0] pos;
    logic [7:0]                sat;
    logic [7:0]                bri;
    h2r_pkg::num_t             red_num;
    h2r_pkg::num_t             green_num;
    h2r_pkg::num_t             blue_num;
    h2r_pkg::chan_t            red;
    h2r_pkg::chan_t            green;
    h2r_pkg::chan_t            blue;

    // A stage loads when it is empty or its word is moving on.
    always_comb begin
        load[4] = !vld_reg[4] || m_ready;
        load[3] = !vld_reg[3] || load[4];
        load[2] = !vld_reg[2] || load[3];
        load[1] = !vld_reg[1] || load[2];
        load[0] = !vld_reg[0] || load[1];

        vld_next[0] = load[0] ? s_valid    : vld_reg[0];
        vld_next[1] = load[1] ? vld_reg[0] : vld_reg[1];
        vld_next[2] = load[2] ? vld_reg[1] : vld_reg[2];
        vld_next[3] = load[3] ? vld_reg[2] : vld_reg[3];
        vld_next[4] = load[4] ? vld_reg[3] : vld_reg[4];

        num_en.first  = load[1];
        num_en.second = load[2];
        div_en.first  = load[3];
        div_en.second = load[4];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    h2r_sector u_sector (
        .aclk    (aclk),
        .en      (load[0]),
        .in_word (s_word),
        .sector  (sector),
        .pos     (pos),
        .sat     (sat),
        .bri     (bri)
    );

    h2r_chan_num u_chan_num (
        .aclk      (aclk),
        .en        (num_en),
        .sector    (sector),
        .pos       (pos),
        .sat       (sat),
        .bri       (bri),
        .red_num   (red_num),
        .green_num (green_num),
        .blue_num  (blue_num)
    );

    h2r_div31 u_div_red (
        .aclk (aclk),
        .en   (div_en),
        .num  (red_num),
        .chan (red)
    );

    h2r_div31 u_div_green (
        .aclk (aclk),
        .en   (div_en),
        .num  (green_num),
        .chan (green)
    );

    h2r_div31 u_div_blue (
        .aclk (aclk),
        .en   (div_en),
        .num  (blue_num),
        .chan (blue)
    );

    assign s_ready = load[0];
    assign m_valid = vld_reg[4];

    always_comb begin
        m_word.packed_color = {red, green, blue, 1'b1};
        m_word.red5         = red;
        m_word.green5       = green;
        m_word.blue5        = blue;
    end

    // Input stalls only when every stage is occupied.
    a_stall_only_when_full: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (vld_reg == 5'b11111)
    ) else $error("input stalled while the pipeline has a free stage");

    // With the receiver ready throughout, an accepted word reaches the output
    // register and raises m_valid.
    a_latency: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 m_ready ##1 m_ready ##1 m_ready ##1 m_ready
        |=> m_valid
    ) else $error("accepted word did not reach the output in time");

    // Reset empties the pipeline.
    a_reset_empty: assert property (
        @(posedge aclk)
        !aresetn |=> (vld_reg == 5'b00000)
    ) else $error("pipeline not empty after reset");

endmodule

/* tb/tb_hsv_to_rgba5551.sv */
module tb_hsv_to_rgba5551;

    // One stimulus row: the HSV word, whether the expected color is typed in,
    // that color, and whether the sender waits for all results before it.
    typedef struct packed {
        logic [15:0] hue;
        logic [7:0]  sat;
        logic [7:0]  val;
        bit          typed;
        logic [15:0] want;
        bit          drain;
    } hsv_row_t;

    localparam int NUM_DIRECTED = 25;
    localparam int RANDOM_WORDS = 1125;
    localparam int TAIL_WORDS   = 120;

    // Extremes, hue wrap, grey, and the first hue of every sector at full
    // saturation are easy to work out by hand. The remaining rows go to the
    // predictor.
    localparam hsv_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{16'd0,     8'd0,   8'd0,   1'b1, 16'h0001, 1'b0},
        '{16'd0,     8'd0,   8'd255, 1'b1, 16'hFFFF, 1'b0},
        '{16'd0,     8'd0,   8'd128, 1'b1, 16'h7BDF, 1'b0},
        '{16'd65535, 8'd0,   8'd255, 1'b1, 16'hFFFF, 1'b0},
        '{16'd0,     8'd255, 8'd255, 1'b1, 16'hF801, 1'b0},
        '{16'd5760,  8'd255, 8'd255, 1'b1, 16'hF801, 1'b0},
        '{16'd65535, 8'd255, 8'd255, 1'b1, 16'hF801, 1'b0},
        '{16'd960,   8'd255, 8'd255, 1'b1, 16'hFFC1, 1'b0},
        '{16'd1920,  8'd255, 8'd255, 1'b1, 16'h07C1, 1'b0},
        '{16'd2880,  8'd255, 8'd255, 1'b1, 16'h07FF, 1'b0},
        '{16'd3840,  8'd255, 8'd255, 1'b1, 16'h003F, 1'b0},
        '{16'd4800,  8'd255, 8'd255, 1'b1, 16'hF83F, 1'b0},
        '{16'd0,     8'd255, 8'd0,   1'b1, 16'h0001, 1'b0},
        '{16'd65535, 8'd255, 8'd0,   1'b1, 16'h0001, 1'b0},
        '{16'd959,   8'd255, 8'd255, 1'b0, 16'h0000, 1'b1},
        '{16'd5759,  8'd255, 8'd255, 1'b0, 16'h0000, 1'b0},
        '{16'd480,   8'd128, 8'd200, 1'b0, 16'h0000, 1'b0},
        '{16'd1440,  8'd1,   8'd255, 1'b0, 16'h0000, 1'b0},
        '{16'd2400,  8'd254, 8'd1,   1'b0, 16'h0000, 1'b0},
        '{16'd3360,  8'd170, 8'd85,  1'b0, 16'h0000, 1'b0},
        '{16'd4320,  8'd85,  8'd170, 1'b0, 16'h0000, 1'b0},
        '{16'd5280,  8'd200, 8'd100, 1'b0, 16'h0000, 1'b0},
        '{16'd6000,  8'd100, 8'd255, 1'b0, 16'h0000, 1'b0},
        '{16'd30000, 8'd37,  8'd222, 1'b0, 16'h0000, 1'b0},
        '{16'd43690, 8'd85,  8'd170, 1'b0, 16'h0000, 1'b0}
    };

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    h2r_pkg::hsv_word_t s_word  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    h2r_pkg::rgb_word_t m_word;

    hsv_row_t           color_feed_q [$];
    h2r_pkg::rgb_word_t rgb_expect_q [$];
    h2r_pkg::rgb_word_t pending_rgb;
    int                 feed_gap      = 0;
    int                 stall_left    = 0;
    int                 mismatch_count = 0;

    hsv_to_rgba5551 DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    always #6 aclk = ~aclk;

    // Exact floor of 31 * num / D, where D is the common denominator.
    function automatic h2r_pkg::chan_t chan_floor(input logic [63:0] num);
        logic [63:0] quo;
        quo = (64'd31 * num) / 64'(h2r_pkg::DENOM);
        return h2r_pkg::chan_t'(quo);
    endfunction

    // Predicts the converted color for one HSV word using exact integer math.
    function automatic h2r_pkg::rgb_word_t predict_rgb(input h2r_pkg::hsv_word_t w);
        logic [63:0]      hue, sat, val, pos, full, vn, pn, qn, tn;
        h2r_pkg::chan_t   red, grn, blu;
        h2r_pkg::sector_t sec;
        hue  = 64'(w.hue);
        sat  = 64'(w.saturation);
        val  = 64'(w.brightness);
        full = 64'(h2r_pkg::FRAC_ONE) * 64'(h2r_pkg::HUE_SECTOR);
        if (sat == 0) begin
            red = chan_floor(val * full);
            grn = red;
            blu = red;
        end else begin
            if (hue >= 64'(h2r_pkg::HUE_TURN)) begin
                hue = 0;
            end
            sec = h2r_pkg::sector_t'(3'(hue / 64'(h2r_pkg::HUE_SECTOR)));
            pos = hue % 64'(h2r_pkg::HUE_SECTOR);
            vn  = val * full;
            pn  = val * (64'(h2r_pkg::FRAC_ONE) - sat) * 64'(h2r_pkg::HUE_SECTOR);
            qn  = val * (full - sat * pos);
            tn  = val * (full - sat * (64'(h2r_pkg::HUE_SECTOR) - pos));
            case (sec)
                h2r_pkg::SEC_RED_YEL: begin
                    red = chan_floor(vn); grn = chan_floor(tn); blu = chan_floor(pn);
                end
                h2r_pkg::SEC_YEL_GRN: begin
                    red = chan_floor(qn); grn = chan_floor(vn); blu = chan_floor(pn);
                end
                h2r_pkg::SEC_GRN_CYN: begin
                    red = chan_floor(pn); grn = chan_floor(vn); blu = chan_floor(tn);
                end
                h2r_pkg::SEC_CYN_BLU: begin
                    red = chan_floor(pn); grn = chan_floor(qn); blu = chan_floor(vn);
                end
                h2r_pkg::SEC_BLU_MAG: begin
                    red = chan_floor(tn); grn = chan_floor(pn); blu = chan_floor(vn);
                end
                default: begin
                    red = chan_floor(vn); grn = chan_floor(pn); blu = chan_floor(qn);
                end
            endcase
        end
        return {red, grn, blu, 1'b1, red, grn, blu};
    endfunction

    // Sender. The expected color is queued when the word is accepted, so the
    // order of expectations always follows the order of accepted words.
    always @(posedge aclk) begin : send_side
        hsv_row_t row;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                rgb_expect_q.push_back(pending_rgb);
            end
            if (!s_valid || s_ready) begin
                if (feed_gap != 0) begin
                    feed_gap--;
                    s_valid <= 1'b0;
                end else if (color_feed_q.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (color_feed_q[0].drain && rgb_expect_q.size() != 0) begin
                    // Hold off until the pipeline has emptied completely.
                    s_valid <= 1'b0;
                end else if (color_feed_q.size() > TAIL_WORDS &&
                             $urandom_range(0, 7) == 0) begin
                    feed_gap = $urandom_range(0, 8);
                    s_valid <= 1'b0;
                end else begin
                    row = color_feed_q.pop_front();
                    s_word  <= {row.hue, row.sat, row.val};
                    s_valid <= 1'b1;
                    if (row.typed) begin
                        pending_rgb = {row.want, row.want[15:11], row.want[10:6],
                                       row.want[5:1]};
                    end else begin
                        pending_rgb = predict_rgb({row.hue, row.sat, row.val});
                    end
                end
            end
        end
    end

    // Receiver. It stalls in bursts and checks every accepted word against
    // the oldest expectation.
    always @(posedge aclk) begin : receive_side
        h2r_pkg::rgb_word_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (rgb_expect_q.size() == 0) begin
                    $error("unexpected result word %h", m_word);
                    mismatch_count++;
                end else begin
                    want = rgb_expect_q.pop_front();
                    if (m_word.packed_color !== want.packed_color) begin
                        $error("packed_color: expected %h, actual %h",
                               want.packed_color, m_word.packed_color);
                        mismatch_count++;
                    end
                    if (m_word.red5 !== want.red5) begin
                        $error("red5: expected %0d, actual %0d", want.red5, m_word.red5);
                        mismatch_count++;
                    end
                    if (m_word.green5 !== want.green5) begin
                        $error("green5: expected %0d, actual %0d",
                               want.green5, m_word.green5);
                        mismatch_count++;
                    end
                    if (m_word.blue5 !== want.blue5) begin
                        $error("blue5: expected %0d, actual %0d", want.blue5, m_word.blue5);
                        mismatch_count++;
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (color_feed_q.size() > TAIL_WORDS && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 8);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : main_flow
        hsv_row_t row;
        int       pick;
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            color_feed_q.push_back(DIRECTED_ROWS[i]);
        end
        // Random words: mostly in-range hues with sector edges and the
        // saturation and brightness extremes weighted up.
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            row = '0;
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                row.hue = 16'($urandom_range(0, h2r_pkg::HUE_TURN - 1));
            end else if (pick == 7) begin
                row.hue = 16'($urandom_range(0, 6) * h2r_pkg::HUE_SECTOR
                              + $urandom_range(0, 2)) - 16'd1;
            end else begin
                row.hue = 16'($urandom);
            end
            pick = $urandom_range(0, 19);
            if (pick < 3) begin
                row.sat = 8'd0;
            end else if (pick < 5) begin
                row.sat = 8'd255;
            end else if (pick == 5) begin
                row.sat = 8'd1;
            end else begin
                row.sat = 8'($urandom);
            end
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                row.val = 8'd0;
            end else if (pick == 1) begin
                row.val = 8'd255;
            end else begin
                row.val = 8'($urandom);
            end
            row.drain = (i % 400 == 0);
            color_feed_q.push_back(row);
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (color_feed_q.size() != 0 || s_valid || rgb_expect_q.size() != 0) begin
            @(posedge aclk);
        end
        // Let any stray word fall out of the five-stage pipeline.
        repeat (12) @(posedge aclk);
        if (mismatch_count == 0 && rgb_expect_q.size() == 0) begin
            $display("tb_hsv_to_rgba5551: PASS");
        end else begin
            $display("tb_hsv_to_rgba5551: FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #4000000;
        $display("tb_hsv_to_rgba5551: FAIL");
        $finish;
    end

endmodule
